// File: rtl/gcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcp_pkg;

  // Saturation limits of the 48-bit Q16.32 format
  localparam logic [47:0] VMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] VMIN = 48'h8000_0000_0000;

  // Unit latencies in cycles
  localparam int MUL_LAT  = 2;
  localparam int SQRT_LAT = 48;
  localparam int DIV_LAT  = 47;
  // Clock edges from the accepting edge to the edge that takes the result
  localparam int ACCEPT_TO_DONE = 5 * MUL_LAT + SQRT_LAT + DIV_LAT + 2;

  // Reset values of the configuration registers
  localparam logic [46:0] GROUND_STIFFNESS_RST = 47'd42949672960000;
  localparam logic [46:0] KINETIC_FRICTION_RST = 47'd3435973837;
  localparam logic [46:0] STATIC_FRICTION_RST  = 47'd4294967296;
  localparam logic [46:0] INVERSE_MASS_RST     = 47'd42949672960;
  localparam logic [46:0] TIME_STEP_RST        = 47'd2147484;
  localparam logic [32:0] DAMPING_RST          = 33'd4290672329;
  localparam logic [47:0] GRAVITY_FORCE_Z_RST  = 48'hFFFF_04DD_2F1B;

  typedef enum logic [2:0] {
    REG_GROUND_STIFFNESS,
    REG_KINETIC_FRICTION,
    REG_STATIC_FRICTION,
    REG_INVERSE_MASS,
    REG_TIME_STEP,
    REG_DAMPING,
    REG_GRAVITY_FORCE_Z
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_AIR,
    MODE_SLIDE,
    MODE_HOLD,
    MODE_BREAK
  } mode_t;

  // Value with its clamp flag
  typedef struct packed {
    logic [47:0] val;
    logic        clip;
  } sres_t;

  // One particle as it travels down the pipeline
  typedef struct packed {
    logic [2:0][47:0] f;
    logic [2:0][47:0] p;
    logic [2:0][47:0] v;
    logic [47:0]      c;
    logic [47:0]      d;
    logic [47:0]      gf;
    logic [47:0]      kf;
    logic [47:0]      smax;
    logic [95:0]      nx;
    logic [95:0]      ny;
    logic             contact;
    logic             vnz;
    logic             stat;
    logic             sat;
    mode_t            mode;
  } item_t;

  function automatic logic [47:0] neg48(input logic [47:0] x);
    neg48 = ~x + 48'd1;
  endfunction

  function automatic logic [47:0] mag48(input logic [47:0] x);
    mag48 = x[47] ? neg48(x) : x;
  endfunction

  // Drop 32 fraction bits of a product magnitude, apply sign, clamp
  function automatic sres_t scale_fix(input logic [95:0] prod, input logic neg);
    logic [63:0] q;
    sres_t r;
    q = prod[95:32];
    r.clip = 1'b0;
    if (neg) begin
      if (q > {16'h0, VMIN}) begin
        r.val = VMIN;
        r.clip = 1'b1;
      end else begin
        r.val = neg48(q[47:0]);
      end
    end else if (q > {16'h0, VMAX}) begin
      r.val = VMAX;
      r.clip = 1'b1;
    end else begin
      r.val = q[47:0];
    end
    return r;
  endfunction

  // Exact sum, clamped to 48 bits
  function automatic sres_t sat_add(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    sres_t r;
    s = {a[47], a} + {b[47], b};
    r.clip = s[48] != s[47];
    if (r.clip) begin
      r.val = s[48] ? VMIN : VMAX;
    end else begin
      r.val = s[47:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gcp_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// 48x48 unsigned multiply: 24-bit partial products, then the sum
module gcp_mul (
  input  wire logic        clk,
  input  wire logic [47:0] a,
  input  wire logic [47:0] b,
  output logic      [95:0] prod
);

  logic [47:0] pp_ll, pp_lh, pp_hl, pp_hh;

  // Form partial products
  always_ff @(posedge clk) begin
    pp_ll <= a[23:0] * b[23:0];
    pp_lh <= a[23:0] * b[47:24];
    pp_hl <= a[47:24] * b[23:0];
    pp_hh <= a[47:24] * b[47:24];
  end

  // Align and sum
  always_ff @(posedge clk) begin
    prod <= {48'h0, pp_ll} + {24'h0, pp_lh, 24'h0} + {24'h0, pp_hl, 24'h0}
            + {pp_hh, 48'h0};
  end

endmodule

`default_nettype wire

// File: rtl/gcp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Floor square root of a 96-bit value, one root bit per stage
module gcp_sqrt (
  input  wire logic        clk,
  input  wire logic [95:0] rad,
  output logic      [47:0] root
);

  localparam int STEPS = gcp_pkg::SQRT_LAT;

  logic [49:0] rem [STEPS];
  logic [47:0] rt  [STEPS];
  logic [95:0] xs  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [49:0] rem_in;
    logic [47:0] rt_in;
    logic [95:0] x_in;
    logic [51:0] trial;
    logic [51:0] tst;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign rt_in  = '0;
      assign x_in   = rad;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign rt_in  = rt[k-1];
      assign x_in   = xs[k-1];
    end

    assign trial = {rem_in, x_in[95:94]};
    assign tst   = {2'b00, rt_in, 2'b01};

    // Try the next root bit; keep it when the remainder covers it
    always_ff @(posedge clk) begin
      if (trial >= tst) begin
        rem[k] <= 50'(trial - tst);
        rt[k]  <= {rt_in[46:0], 1'b1};
      end else begin
        rem[k] <= trial[49:0];
        rt[k]  <= {rt_in[46:0], 1'b0};
      end
      xs[k] <= {x_in[93:0], 2'b00};
    end
  end

  assign root = rt[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/gcp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divide, one quotient bit per stage; needs num / 2^47 < den
module gcp_div (
  input  wire logic        clk,
  input  wire logic [95:0] num,
  input  wire logic [47:0] den,
  output logic      [46:0] quo
);

  localparam int STEPS = gcp_pkg::DIV_LAT;

  logic [47:0] rem [STEPS];
  logic [95:0] ns  [STEPS];
  logic [47:0] ds  [STEPS];
  logic [46:0] qs  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [47:0] rem_in;
    logic [95:0] n_in;
    logic [47:0] d_in;
    logic [46:0] q_in;
    logic [48:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = num[94:47];
      assign n_in   = {num[46:0], 49'h0};
      assign d_in   = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign n_in   = ns[k-1];
      assign d_in   = ds[k-1];
      assign q_in   = qs[k-1];
    end

    assign trial = {rem_in, n_in[95]};

    // Subtract the divisor when it fits
    always_ff @(posedge clk) begin
      if (trial >= {1'b0, d_in}) begin
        rem[k] <= 48'(trial - {1'b0, d_in});
        qs[k]  <= {q_in[45:0], 1'b1};
      end else begin
        rem[k] <= trial[47:0];
        qs[k]  <= {q_in[45:0], 1'b0};
      end
      ns[k] <= {n_in[94:0], 1'b0};
      ds[k] <= d_in;
    end
  end

  assign quo = qs[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/gcp_delay.sv
`timescale 1ns / 1ps
`default_nettype none

// Carry a request and its valid bit down a register chain
module gcp_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_vld,
  input  wire logic [W-1:0] in_data,
  output logic              out_vld,
  output logic      [W-1:0] out_data
);

  logic [N-1:0] vld;
  logic [W-1:0] dat [N];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= in_vld;
      for (int i = 1; i < N; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    dat[0] <= in_data;
    for (int i = 1; i < N; i++) begin
      dat[i] <= dat[i-1];
    end
  end

  assign out_vld  = vld[N-1];
  assign out_data = dat[N-1];

endmodule

`default_nettype wire

// File: rtl/ground_contact_particle_update_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Euler step of one particle with ground penalty force and Coulomb friction, Q16.32.
// A request is taken on every clock where start is high; busy is high only in reset.
// Each request gives one result, marked by done for one cycle; results leave in
// request order and cannot be held off. The latency is set by the 48-stage square
// root for the friction direction, the 47-stage divider after it and five two-stage
// multiplies in series with them (one ahead of the root, four for the integration
// after the divider).
// Configuration writes take effect at once and belong in idle time.
module ground_contact_particle_update_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [47:0] cfg_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [47:0] spring_fx,
  input  wire logic signed [47:0] spring_fy,
  input  wire logic signed [47:0] spring_fz,
  input  wire logic signed [47:0] pos_x,
  input  wire logic signed [47:0] pos_y,
  input  wire logic signed [47:0] pos_z,
  input  wire logic signed [47:0] vel_x,
  input  wire logic signed [47:0] vel_y,
  input  wire logic signed [47:0] vel_z,
  output logic                    done,
  output logic signed      [47:0] new_pos_x,
  output logic signed      [47:0] new_pos_y,
  output logic signed      [47:0] new_pos_z,
  output logic signed      [47:0] new_vel_x,
  output logic signed      [47:0] new_vel_y,
  output logic signed      [47:0] new_vel_z,
  output logic             [1:0]  contact_mode,
  output logic                    saturated
);

  localparam int IW     = $bits(gcp_pkg::item_t);
  localparam int LM     = gcp_pkg::MUL_LAT;
  localparam int WAIT_N = gcp_pkg::SQRT_LAT - 3 * gcp_pkg::MUL_LAT;

  // Configuration registers
  logic [46:0] ground_stiffness, kinetic_friction, static_friction;
  logic [46:0] inverse_mass, time_step;
  logic [32:0] damping;
  logic [47:0] gravity_force_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_stiffness <= gcp_pkg::GROUND_STIFFNESS_RST;
      kinetic_friction <= gcp_pkg::KINETIC_FRICTION_RST;
      static_friction  <= gcp_pkg::STATIC_FRICTION_RST;
      inverse_mass     <= gcp_pkg::INVERSE_MASS_RST;
      time_step        <= gcp_pkg::TIME_STEP_RST;
      damping          <= gcp_pkg::DAMPING_RST;
      gravity_force_z  <= gcp_pkg::GRAVITY_FORCE_Z_RST;
    end else if (cfg_write) begin
      case (gcp_pkg::cfg_idx_t'(cfg_index))
        gcp_pkg::REG_GROUND_STIFFNESS: ground_stiffness <= cfg_data[46:0];
        gcp_pkg::REG_KINETIC_FRICTION: kinetic_friction <= cfg_data[46:0];
        gcp_pkg::REG_STATIC_FRICTION:  static_friction  <= cfg_data[46:0];
        gcp_pkg::REG_INVERSE_MASS:     inverse_mass     <= cfg_data[46:0];
        gcp_pkg::REG_TIME_STEP:        time_step        <= cfg_data[46:0];
        gcp_pkg::REG_DAMPING:          damping          <= cfg_data[32:0];
        gcp_pkg::REG_GRAVITY_FORCE_Z:  gravity_force_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // Stage items and valid bits, named by cycle after the input register
  gcp_pkg::item_t s0, a0, s2, a2, s4, a4, s6, a6, s8, a8, s50, a50;
  gcp_pkg::item_t s97, a97, s99, a99, s101, a101, s103, a103, s105;
  gcp_pkg::item_t s0_next;
  logic v0, v2, v4, v6, v8, v50, v97, v99, v101, v103, v105;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
  end

  always_comb begin
    s0_next      = '0;
    s0_next.f[0] = spring_fx;
    s0_next.f[1] = spring_fy;
    s0_next.f[2] = spring_fz;
    s0_next.p[0] = pos_x;
    s0_next.p[1] = pos_y;
    s0_next.p[2] = pos_z;
    s0_next.v[0] = vel_x;
    s0_next.v[1] = vel_y;
    s0_next.v[2] = vel_z;
  end

  always_ff @(posedge clk) begin
    s0 <= s0_next;
  end

  // Gravity, contact test and choice of the friction direction
  gcp_pkg::sres_t fz1;
  always_comb begin
    a0         = s0;
    a0.contact = s0.p[2][47];
    a0.vnz     = (s0.v[0] != '0) || (s0.v[1] != '0);
    a0.c       = a0.vnz ? s0.v[0] : s0.f[0];
    a0.d       = a0.vnz ? s0.v[1] : s0.f[1];
    fz1        = gcp_pkg::sat_add(s0.f[2], gravity_force_z);
    a0.f[2]    = fz1.val;
    a0.sat     = fz1.clip;
    a0.mode    = gcp_pkg::MODE_AIR;
  end

  logic [95:0] p_pz, p_cc, p_dd;
  gcp_mul u_mul_pz (.clk, .a(gcp_pkg::mag48(s0.p[2])), .b(gcp_pkg::mag48(s0.p[2])),
                    .prod(p_pz));
  gcp_mul u_mul_cc (.clk, .a(gcp_pkg::mag48(a0.c)), .b(gcp_pkg::mag48(a0.c)), .prod(p_cc));
  gcp_mul u_mul_dd (.clk, .a(gcp_pkg::mag48(a0.d)), .b(gcp_pkg::mag48(a0.d)), .prod(p_dd));

  gcp_delay #(.W(IW), .N(LM)) u_dly_a (.clk, .rst, .in_vld(v0), .in_data(a0),
                                       .out_vld(v2), .out_data(s2));

  // Root of the squared direction length
  logic [47:0] hyp;
  gcp_sqrt u_sqrt (.clk, .rad(p_cc + p_dd), .root(hyp));

  // Height squared, then ground force
  gcp_pkg::sres_t pz2;
  always_comb begin
    a2     = s2;
    pz2    = gcp_pkg::scale_fix(p_pz, 1'b0);
    a2.sat = s2.sat | pz2.clip;
  end

  logic [95:0] p_gf;
  gcp_mul u_mul_gf (.clk, .a({1'b0, ground_stiffness}), .b(pz2.val), .prod(p_gf));

  gcp_delay #(.W(IW), .N(LM)) u_dly_b (.clk, .rst, .in_vld(v2), .in_data(a2),
                                       .out_vld(v4), .out_data(s4));

  gcp_pkg::sres_t gf;
  always_comb begin
    a4     = s4;
    gf     = gcp_pkg::scale_fix(p_gf, 1'b0);
    a4.gf  = gf.val;
    a4.sat = s4.sat | gf.clip;
  end

  logic [95:0] p_kf, p_sm;
  gcp_mul u_mul_kf (.clk, .a({1'b0, kinetic_friction}), .b(gf.val), .prod(p_kf));
  gcp_mul u_mul_sm (.clk, .a({1'b0, static_friction}), .b(gf.val), .prod(p_sm));

  gcp_delay #(.W(IW), .N(LM)) u_dly_c (.clk, .rst, .in_vld(v4), .in_data(a4),
                                       .out_vld(v6), .out_data(s6));

  // Friction limits and ground push on z
  gcp_pkg::sres_t kf, sm, fz2;
  always_comb begin
    a6      = s6;
    kf      = gcp_pkg::scale_fix(p_kf, 1'b0);
    sm      = gcp_pkg::scale_fix(p_sm, 1'b0);
    fz2     = gcp_pkg::sat_add(s6.f[2], s6.gf);
    a6.kf   = kf.val;
    a6.smax = sm.val;
    if (s6.contact) begin
      a6.f[2] = fz2.val;
      a6.sat  = s6.sat | kf.clip | fz2.clip | (sm.clip & ~s6.vnz);
    end
  end

  logic [95:0] p_nx, p_ny;
  gcp_mul u_mul_nx (.clk, .a(kf.val), .b(gcp_pkg::mag48(s6.c)), .prod(p_nx));
  gcp_mul u_mul_ny (.clk, .a(kf.val), .b(gcp_pkg::mag48(s6.d)), .prod(p_ny));

  gcp_delay #(.W(IW), .N(LM)) u_dly_d (.clk, .rst, .in_vld(v6), .in_data(a6),
                                       .out_vld(v8), .out_data(s8));

  always_comb begin
    a8    = s8;
    a8.nx = p_nx;
    a8.ny = p_ny;
  end

  // Hold numerators until the root arrives
  gcp_delay #(.W(IW), .N(WAIT_N)) u_dly_e (.clk, .rst, .in_vld(v8), .in_data(a8),
                                           .out_vld(v50), .out_data(s50));

  always_comb begin
    a50      = s50;
    a50.stat = s50.smax >= hyp;
  end

  logic [46:0] q_x, q_y;
  gcp_div u_div_x (.clk, .num(s50.nx), .den(hyp), .quo(q_x));
  gcp_div u_div_y (.clk, .num(s50.ny), .den(hyp), .quo(q_y));

  gcp_delay #(.W(IW), .N(gcp_pkg::DIV_LAT)) u_dly_f (.clk, .rst, .in_vld(v50),
                                                     .in_data(a50), .out_vld(v97),
                                                     .out_data(s97));

  // Resolve contact mode and horizontal friction
  logic [47:0]    dx, dy;
  gcp_pkg::sres_t fx1, fy1;
  always_comb begin
    a97 = s97;
    dx  = s97.c[47] ? {1'b0, q_x} : gcp_pkg::neg48({1'b0, q_x});
    dy  = s97.d[47] ? {1'b0, q_y} : gcp_pkg::neg48({1'b0, q_y});
    fx1 = gcp_pkg::sat_add(s97.f[0], dx);
    fy1 = gcp_pkg::sat_add(s97.f[1], dy);
    if (!s97.contact) begin
      a97.mode = gcp_pkg::MODE_AIR;
    end else if (!s97.vnz && s97.stat) begin
      a97.mode = gcp_pkg::MODE_HOLD;
      a97.f[0] = '0;
      a97.f[1] = '0;
    end else begin
      a97.mode = s97.vnz ? gcp_pkg::MODE_SLIDE : gcp_pkg::MODE_BREAK;
      a97.f[0] = fx1.val;
      a97.f[1] = fy1.val;
      a97.sat  = s97.sat | fx1.clip | fy1.clip;
    end
  end

  // Per-axis integration chain
  logic [2:0][95:0] p_acc, p_dv, p_dmp, p_dp;
  gcp_pkg::sres_t [2:0] acc, dv, v1, vdmp, dp, p1;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    gcp_mul u_mul_acc (.clk, .a(gcp_pkg::mag48(a97.f[k])), .b({1'b0, inverse_mass}),
                       .prod(p_acc[k]));
    gcp_mul u_mul_dv  (.clk, .a(gcp_pkg::mag48(acc[k].val)), .b({1'b0, time_step}),
                       .prod(p_dv[k]));
    gcp_mul u_mul_dmp (.clk, .a(gcp_pkg::mag48(v1[k].val)), .b({15'h0, damping}),
                       .prod(p_dmp[k]));
    gcp_mul u_mul_dp  (.clk, .a(gcp_pkg::mag48(vdmp[k].val)), .b({1'b0, time_step}),
                       .prod(p_dp[k]));
  end

  gcp_delay #(.W(IW), .N(LM)) u_dly_g (.clk, .rst, .in_vld(v97), .in_data(a97),
                                       .out_vld(v99), .out_data(s99));

  // Acceleration
  always_comb begin
    a99 = s99;
    for (int k = 0; k < 3; k++) begin
      acc[k]   = gcp_pkg::scale_fix(p_acc[k], s99.f[k][47]);
      a99.f[k] = acc[k].val;
      a99.sat  = a99.sat | acc[k].clip;
    end
  end

  gcp_delay #(.W(IW), .N(LM)) u_dly_h (.clk, .rst, .in_vld(v99), .in_data(a99),
                                       .out_vld(v101), .out_data(s101));

  // Velocity update
  always_comb begin
    a101 = s101;
    for (int k = 0; k < 3; k++) begin
      dv[k]     = gcp_pkg::scale_fix(p_dv[k], s101.f[k][47]);
      v1[k]     = gcp_pkg::sat_add(s101.v[k], dv[k].val);
      a101.v[k] = v1[k].val;
      a101.sat  = a101.sat | dv[k].clip | v1[k].clip;
    end
  end

  gcp_delay #(.W(IW), .N(LM)) u_dly_i (.clk, .rst, .in_vld(v101), .in_data(a101),
                                       .out_vld(v103), .out_data(s103));

  // Damping
  always_comb begin
    a103 = s103;
    for (int k = 0; k < 3; k++) begin
      vdmp[k]   = gcp_pkg::scale_fix(p_dmp[k], s103.v[k][47]);
      a103.v[k] = vdmp[k].val;
      a103.sat  = a103.sat | vdmp[k].clip;
    end
  end

  gcp_delay #(.W(IW), .N(LM)) u_dly_j (.clk, .rst, .in_vld(v103), .in_data(a103),
                                       .out_vld(v105), .out_data(s105));

  // Position update
  logic sat_all;
  always_comb begin
    sat_all = s105.sat;
    for (int k = 0; k < 3; k++) begin
      dp[k]   = gcp_pkg::scale_fix(p_dp[k], s105.v[k][47]);
      p1[k]   = gcp_pkg::sat_add(s105.p[k], dp[k].val);
      sat_all = sat_all | dp[k].clip | p1[k].clip;
    end
  end

  // Drive the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v105;
    end
  end

  always_ff @(posedge clk) begin
    new_pos_x    <= p1[0].val;
    new_pos_y    <= p1[1].val;
    new_pos_z    <= p1[2].val;
    new_vel_x    <= s105.v[0];
    new_vel_y    <= s105.v[1];
    new_vel_z    <= s105.v[2];
    contact_mode <= s105.mode;
    saturated    <= sat_all;
  end

endmodule

`default_nettype wire

// File: rtl/gcp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gcp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic signed [47:0] pos_z,
  input wire logic               done,
  input wire logic signed [47:0] new_vel_x,
  input wire logic signed [47:0] new_vel_y,
  input wire logic        [1:0]  contact_mode
);

  localparam int LAT = gcp_pkg::ACCEPT_TO_DONE;

  // Never refuse a request outside reset
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy outside reset");

  // Every result comes from a request taken a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  // Contact modes only for particles below the ground
  a_contact: assert property (@(posedge clk) disable iff (rst)
    (done && contact_mode != gcp_pkg::MODE_AIR) |-> $past(pos_z[47], LAT))
    else $error("contact reported above ground");

  // Static hold leaves no horizontal velocity
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (done && contact_mode == gcp_pkg::MODE_HOLD) |-> (new_vel_x == '0 && new_vel_y == '0))
    else $error("static hold with horizontal velocity");

endmodule

bind ground_contact_particle_update_core gcp_checker u_gcp_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .pos_z(pos_z),
  .done(done),
  .new_vel_x(new_vel_x),
  .new_vel_y(new_vel_y),
  .contact_mode(contact_mode)
);

`default_nettype wire
